>>> sv/concentric_disc_sample_map_unit_defines.svh
// Assertion macros for the concentric disc sample map unit.
// Uses the clock and reset port names of the module that includes it.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef CONCENTRIC_DISC_SAMPLE_MAP_UNIT_DEFINES_SVH
`define CONCENTRIC_DISC_SAMPLE_MAP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define CDSM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define CDSM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CDSM_ASSERT_IMP(lbl, ante, cons, msg)
`define CDSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/cdsm_pkg.sv
// Shared constants, word types and the arctangent table of the disc sample map.
// Used by every module of the block; depends on nothing else.
package cdsm_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 30;
   localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 18;
   localparam int MAG_W    = 17;
   localparam int REM_W    = MAG_W + 1;
   localparam int ANG_W    = 32;
   localparam int QUO_W    = 30;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   localparam int REQ_DATA_W = 2 * SAMPLE_W;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * OUT_W;

   // CORDIC gain in Q.32 and the scaling of the start vector into Q.FRAC_BITS.
   localparam int GAIN_W     = 32;
   localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'h9B74EDA8;
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int GAIN_SHIFT = 48 - FRAC_BITS;
   localparam logic [PROD_W:0] GAIN_ROUND = (PROD_W + 1)'(1) << (GAIN_SHIFT - 1);

   localparam int CW        = FRAC_BITS + 3;
   localparam int CONV_W    = CW + 16;
   localparam int OUT_SHR   = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
   localparam int OUT_SHL   = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
   localparam int OUT_ROUND = (1 << OUT_SHR) >> 1;
   localparam int OUT_MAX   = 65536;

   // atan(2^-i) in binary angle units, 2^32 per turn.
   localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Values that ride alongside the divider.
   typedef struct packed {
      logic [MAG_W-1:0] radius;
      logic [1:0]       quad_base;
      logic             neg;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] den;
      logic [QUO_W-1:0] quo;
      side_type         side;
   } div_type;

   typedef struct packed {
      logic [CW-1:0]    x;
      logic [CW-1:0]    y;
      logic [ANG_W-1:0] z;
      logic [1:0]       quad;
   } rot_type;

   typedef struct packed {
      logic [OUT_W-1:0] disc_y;
      logic [OUT_W-1:0] disc_x;
   } point_type;

endpackage

>>> sv/cdsm_front.sv
// Input stage: centers the sample pair, picks the wedge and sets up the division.
// Depends on cdsm_pkg.
module cdsm_front import cdsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SAMPLE_W-1:0] u_sample,
   input  logic [SAMPLE_W-1:0] v_sample,
   output logic                out_valid,
   output div_type             out_word
);

   logic signed [OUT_W-1:0] a_val;
   logic signed [OUT_W-1:0] b_val;
   logic signed [OUT_W:0]   ab_sum;
   logic                    a_neg;
   logic                    b_neg;
   logic [MAG_W-1:0]        a_mag;
   logic [MAG_W-1:0]        b_mag;
   logic [MAG_W-1:0]        num_mag;
   logic [MAG_W-1:0]        den_mag;
   logic                    center;
   logic                    valid_ff;
   div_type                 word_ff;
   div_type                 word_in;

   assign a_val  = $signed({1'b0, u_sample, 1'b0} - 18'h10000);
   assign b_val  = $signed({1'b0, v_sample, 1'b0} - 18'h10000);
   assign ab_sum = a_val + b_val;
   assign a_neg  = a_val[OUT_W-1];
   assign b_neg  = b_val[OUT_W-1];
   assign a_mag  = a_neg ? MAG_W'(-a_val) : MAG_W'(a_val);
   assign b_mag  = b_neg ? MAG_W'(-b_val) : MAG_W'(b_val);

   // The dominant magnitude is both the radius and the divisor.  The neg flag
   // says whether the scaled ratio is subtracted from the wedge base angle.
   always_comb begin
      word_in.side.quad_base = 2'd0;
      word_in.side.neg       = 1'b0;
      num_mag                = '0;
      den_mag                = '0;
      center                 = 1'b0;
      if (ab_sum > 19'sd0) begin
         if (a_val > b_val) begin
            num_mag                = b_mag;
            den_mag                = a_mag;
            word_in.side.quad_base = 2'd0;
            word_in.side.neg       = b_neg;
         end else begin
            num_mag                = a_mag;
            den_mag                = b_mag;
            word_in.side.quad_base = 2'd1;
            word_in.side.neg       = !a_neg;
         end
      end else begin
         if (a_val < b_val) begin
            num_mag                = b_mag;
            den_mag                = a_mag;
            word_in.side.quad_base = 2'd2;
            word_in.side.neg       = !b_neg;
         end else begin
            num_mag                = a_mag;
            den_mag                = b_mag;
            center                 = (b_mag == '0);
            word_in.side.quad_base = center ? 2'd0 : 2'd3;
            word_in.side.neg       = a_neg;
         end
      end
      word_in.side.radius = den_mag;
      word_in.rem         = REM_W'(num_mag);
      word_in.den         = center ? MAG_W'(1) : den_mag;
      word_in.quo         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> sv/cdsm_div.sv
// Pipelined restoring divider for the wedge ratio, two quotient bits per stage.
// Depends on cdsm_pkg.
module cdsm_div import cdsm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  div_type          in_word,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output side_type         out_side
);

   logic [DIV_STAGES-1:0] valid_ff;
   div_type               stage_ff [DIV_STAGES];
   div_type               stage_in [DIV_STAGES];

   // The very first step compares the numerator itself, which is never
   // larger than the divisor; every later step doubles the remainder first.
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                               input logic [MAG_W-1:0] den,
                                               input logic             first);
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] dext;
      trial = first ? rem : {rem[REM_W-2:0], 1'b0};
      dext  = REM_W'(den);
      if (trial >= dext) begin
         return {1'b1, trial - dext};
      end
      return {1'b0, trial};
   endfunction

   always_comb begin
      div_type          w;
      logic [REM_W:0]   res;
      w = in_word;
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            res   = div_step(w.rem, w.den, (s == 0) && (k == 0));
            w.rem = res[REM_W-1:0];
            w.quo = {w.quo[QUO_W-2:0], res[REM_W]};
         end
         stage_in[s] = w;
         w = stage_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = stage_ff[DIV_STAGES-1].quo;
   assign out_side  = stage_ff[DIV_STAGES-1].side;

endmodule

>>> sv/cdsm_cordic.sv
// Angle and gain setup, pipelined CORDIC rotation, quadrant fix-up and Q1.16 output.
// Depends on cdsm_pkg.
module cdsm_cordic import cdsm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [QUO_W-1:0] in_quo,
   input  side_type         in_side,
   output logic             out_valid,
   output point_type        out_point
);

   localparam int TAIL = CORDIC_N + 4;

   logic [TAIL-1:0]   valid_ff;
   logic [ANG_W-1:0]  theta_ff;
   logic [ANG_W-1:0]  theta_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W:0]   prod_round;
   logic [1:0]        quad;
   rot_type           start_ff;
   rot_type           start_in;
   rot_type           rot_ff [CORDIC_N];
   rot_type           rot_in [CORDIC_N];
   rot_type           last_rot;
   logic [CW-1:0]     qx_ff;
   logic [CW-1:0]     qx_in;
   logic [CW-1:0]     qy_ff;
   logic [CW-1:0]     qy_in;
   point_type         point_ff;
   point_type         point_in;

   function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
      logic signed [CONV_W-1:0] e;
      e = CONV_W'($signed(v));
      e = (e + CONV_W'(OUT_ROUND)) >>> OUT_SHR;
      e = e <<< OUT_SHL;
      if (e > CONV_W'(OUT_MAX)) begin
         e = CONV_W'(OUT_MAX);
      end else if (e < CONV_W'(-OUT_MAX)) begin
         e = CONV_W'(-OUT_MAX);
      end
      return e[OUT_W-1:0];
   endfunction

   // Angle with 2^32 per turn: wedge base plus or minus the ratio.
   assign theta_in = {in_side.quad_base, {(ANG_W-2){1'b0}}} +
                     (in_side.neg ? -ANG_W'(in_quo) : ANG_W'(in_quo));
   assign prod_in  = PROD_W'(in_side.radius) * PROD_W'(GAIN_Q32);

   // Nearest quarter turn is taken out and applied after the rotation.
   assign quad       = theta_ff[ANG_W-1:ANG_W-2] + {1'b0, theta_ff[ANG_W-3]};
   assign prod_round = {1'b0, prod_ff} + GAIN_ROUND;

   always_comb begin
      start_in.quad = quad;
      start_in.z    = theta_ff - {quad, {(ANG_W-2){1'b0}}};
      start_in.x    = CW'(prod_round >> GAIN_SHIFT);
      start_in.y    = '0;
   end

   always_comb begin
      rot_type          w;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      w = start_ff;
      for (int s = 0; s < CORDIC_N; s++) begin
         dx = $signed(w.y) >>> s;
         dy = $signed(w.x) >>> s;
         if (!w.z[ANG_W-1]) begin
            w.x = w.x - dx;
            w.y = w.y + dy;
            w.z = w.z - ATAN_TAB[s];
         end else begin
            w.x = w.x + dx;
            w.y = w.y - dy;
            w.z = w.z + ATAN_TAB[s];
         end
         rot_in[s] = w;
         w = rot_ff[s];
      end
   end

   assign last_rot = rot_ff[CORDIC_N-1];

   always_comb begin
      case (last_rot.quad)
         2'd1: begin
            qx_in = -last_rot.y;
            qy_in = last_rot.x;
         end
         2'd2: begin
            qx_in = -last_rot.x;
            qy_in = -last_rot.y;
         end
         2'd3: begin
            qx_in = last_rot.y;
            qy_in = -last_rot.x;
         end
         default: begin
            qx_in = last_rot.x;
            qy_in = last_rot.y;
         end
      endcase
   end

   assign point_in.disc_x = to_out(qx_ff);
   assign point_in.disc_y = to_out(qy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TAIL-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         theta_ff <= theta_in;
         prod_ff  <= prod_in;
         start_ff <= start_in;
         for (int s = 0; s < CORDIC_N; s++) begin
            rot_ff[s] <= rot_in[s];
         end
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         point_ff <= point_in;
      end
   end

   assign out_valid = valid_ff[TAIL-1];
   assign out_point = point_ff;

endmodule

>>> sv/concentric_disc_sample_map_unit.sv
// Top level of the concentric square-to-disc sample map: front end, divider,
// CORDIC pipeline and the output register with its skid stage.
// Depends on cdsm_pkg, cdsm_front, cdsm_div, cdsm_cordic and the defines header.
//
//   channel | direction | word contents (lowest bits first)
//   req_*   | in        | u_sample[15:0], v_sample[31:16]
//   rsp_*   | out       | disc_x[17:0], disc_y[35:18], zero[39:36]
//
// One word is taken in every cycle while req_tready is high.  The pipeline has one
// front-end stage, 15 divider stages, two angle and gain stages, one stage per
// rotation (16 with CORDIC_N = 16), quadrant and output stages, and the output register.
// Reset is synchronous and clears only the valid bits.  When the result side stalls,
// one more word lands in the skid register and then req_tready drops until it drains.
`include "concentric_disc_sample_map_unit_defines.svh"

module concentric_disc_sample_map_unit import cdsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // u_sample[15:0], v_sample[31:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // disc_x[17:0], disc_y[35:18], zero pad
);

   logic             en;
   logic             front_valid;
   div_type          front_word;
   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type         div_side;
   logic             pipe_valid;
   point_type        pipe_point;
   logic             take;

   logic             out_valid_ff;
   logic             out_valid_in;
   point_type        out_data_ff;
   point_type        out_data_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   point_type        skid_data_ff;
   point_type        skid_data_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   cdsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .u_sample  (req_tdata[SAMPLE_W-1:0]),
      .v_sample  (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   cdsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   cdsm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_side   (div_side),
      .out_valid (pipe_valid),
      .out_point (pipe_point)
   );

   assign take = out_valid_ff && rsp_tready;

   // While the skid register holds a word the pipeline is frozen, so the
   // output register refills from the skid register first.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = pipe_point;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pipe_point;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_data_ff};

   `CDSM_ASSERT_IMP(a_skid_needs_out, skid_valid_ff, out_valid_ff, "skid word without output word")
   `CDSM_ASSERT_NXT(a_skid_holds, skid_valid_ff && !rsp_tready, skid_valid_ff && $stable(skid_data_ff), "skid word lost while stalled")
   `CDSM_ASSERT_IMP(a_skid_fill_cause, $rose(skid_valid_ff), $past(out_valid_ff) && !$past(rsp_tready), "skid filled without a stall")
   `CDSM_ASSERT_IMP(a_out_range, out_valid_ff, ($signed(out_data_ff.disc_x) <= 18'sd65536) && ($signed(out_data_ff.disc_x) >= -18'sd65536) && ($signed(out_data_ff.disc_y) <= 18'sd65536) && ($signed(out_data_ff.disc_y) >= -18'sd65536), "result outside the unit range")

endmodule
